@@ design/imaq_pkg.sv @@
// Shared types and constants for the interval map block.
// Used by imaq_cell and interval_map_assign_query; no dependencies.
package imaq_pkg;

  localparam int Entries  = 32;
  localparam int AddrBits = 32;
  localparam int TagBits  = 16;
  localparam int CntW     = $clog2(Entries + 1);
  localparam int IdxW     = $clog2(Entries);

  typedef struct packed {
    logic [AddrBits-1:0] key;
    logic [TagBits-1:0]  tag;
  } entry_t;

  typedef enum logic [1:0] {
    CmdAssign   = 2'd0,
    CmdQuery    = 2'd1,
    CmdQueryAll = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StFull   = 2'd1,
    StBeyond = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SIdle,
    SScan,
    SWrite,
    SQuery,
    SResp
  } state_e;

  // per-cell controls from the sequencer
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t data;
  } cell_ctl_t;

endpackage

@@ design/imaq_cell.sv @@
// One breakpoint slot of the table chain.
// Depends on imaq_pkg; takes its neighbour's entry when the chain shifts.
module imaq_cell import imaq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  entry_t    nb_i,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = nb_i;
    end
    if (ctl_i.load) begin
      entry_d = ctl_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ design/interval_map_assign_query.sv @@
// Interval map: sorted breakpoint table held in a chain of cells, streamed past a sequencer.
// Assign: one scan pass, then one rewrite pass if the result fits; a zero or wrapping size skips both.
// Query: one pass over the chain; at most one result per cycle, and the pass waits while the output stalls.
// One item in flight; the next is taken once the previous one has finished its passes.
// Reset (async, active low): table holds one entry {0, tag 0}; root tag 0.
// Depends on imaq_pkg and imaq_cell.
module interval_map_assign_query import imaq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [TagBits-1:0]  cfg_root_source_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          command_i,
  input  logic [AddrBits-1:0] address_i,
  input  logic [AddrBits-1:0] size_i,
  input  logic [TagBits-1:0]  source_tag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [TagBits-1:0]  range_source_o,
  output logic [AddrBits-1:0] range_begin_o,
  output logic [AddrBits:0]   range_end_o,
  output logic                empty_res_o,
  output logic                last_o,
  output logic [TagBits-1:0]  root_source_res_o
);

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d, rem_q, rem_d, rm_q, rm_d;
  logic [AddrBits-1:0] kb_q, kb_d;
  logic [AddrBits:0] ke_q, ke_d;
  logic [TagBits-1:0] src_q, src_d, tib_q, tib_d, tie_q, tie_d, root_q, root_d;
  logic all_q, all_d, insb_q, insb_d, inse_q, inse_d;
  logic held_v_q, held_v_d, any_q, any_d;
  entry_t held_q, held_d;
  status_e resp_q, resp_d;

  logic out_valid_q;
  logic [1:0] status_q, status_d;
  logic [TagBits-1:0] rsrc_q, rsrc_d;
  logic [AddrBits-1:0] rbeg_q, rbeg_d;
  logic [AddrBits:0] rend_q, rend_d;
  logic empty_q, empty_d, last_q, last_d;
  logic [TagBits-1:0] rroot_q;

  entry_t cells [Entries];
  cell_ctl_t ctl [Entries];
  entry_t head, push_data;
  logic pop, push, emit, can_emit;
  logic [IdxW-1:0] wpos;
  logic [AddrBits:0] sum, head33;
  logic [CntW:0] needed;
  logic first, tail_kept;

  assign head     = cells[0];
  assign head33   = {1'b0, head.key};
  assign can_emit = !out_valid_q || out_ready_i;
  assign sum      = {1'b0, address_i} + {1'b0, size_i};
  assign first     = tib_q != src_q;
  assign tail_kept = tie_q != src_q;
  assign needed = {1'b0, cnt_q} - {1'b0, rm_q}
                + {{CntW{1'b0}}, first && (kb_q != '0)} + {{CntW{1'b0}}, tail_kept};

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rem_d = rem_q; rm_d = rm_q;
    kb_d = kb_q; ke_d = ke_q; src_d = src_q; tib_d = tib_q; tie_d = tie_q;
    root_d = root_q; all_d = all_q; insb_d = insb_q; inse_d = inse_q;
    held_v_d = held_v_q; held_d = held_q; any_d = any_q; resp_d = resp_q;
    pop = 1'b0; push = 1'b0; push_data = head; emit = 1'b0;
    status_d = StOk; rsrc_d = '0; rbeg_d = '0; rend_d = '0; empty_d = 1'b1; last_d = 1'b1;

    unique case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          kb_d = address_i; ke_d = sum; src_d = source_tag_i;
          rem_d = cnt_q; rm_d = '0; held_v_d = 1'b0; any_d = 1'b0;
          all_d = 1'b0; resp_d = StOk;
          case (command_i)
            CmdAssign: begin
              if (size_i == '0 || sum[AddrBits]) begin
                state_d = SResp;
              end else begin
                state_d = SScan;
              end
            end
            CmdQuery: begin
              if (sum[AddrBits] && (sum[AddrBits-1:0] != '0)) begin
                resp_d = StBeyond; state_d = SResp;
              end else begin
                state_d = SQuery;
              end
            end
            CmdQueryAll: begin
              all_d = 1'b1; kb_d = '0; state_d = SQuery;
            end
            default: state_d = SResp;
          endcase
        end
      end
      SScan: begin
        if (rem_q != '0) begin
          pop = 1'b1; push = 1'b1; rem_d = rem_q - 1'b1;
          if (head.key < kb_q || head.key == '0) begin
            tib_d = head.tag;
          end
          if (head33 <= ke_q) begin
            tie_d = head.tag;
            if (head.key >= kb_q && head.key != '0) begin
              rm_d = rm_q + 1'b1;
            end
          end
        end else if (needed > (CntW+1)'(Entries)) begin
          resp_d = StFull; state_d = SResp;
        end else begin
          rem_d = cnt_q; state_d = SWrite;
          insb_d = first && (kb_q != '0);
          inse_d = tail_kept;
        end
      end
      SWrite: begin
        if (rem_q != '0 && (head.key < kb_q || head.key == '0)) begin
          pop = 1'b1; push = 1'b1; rem_d = rem_q - 1'b1;
          if (head.key == '0 && kb_q == '0) begin
            push_data.tag = src_q; root_d = src_q;
          end
        end else if (rem_q != '0 && head33 <= ke_q) begin
          pop = 1'b1; rem_d = rem_q - 1'b1;        // painted over
        end else if (insb_q) begin
          push = 1'b1; push_data.key = kb_q; push_data.tag = src_q; insb_d = 1'b0;
        end else if (inse_q) begin
          push = 1'b1; push_data.key = ke_q[AddrBits-1:0]; push_data.tag = tie_q;
          inse_d = 1'b0;
        end else if (rem_q != '0) begin
          pop = 1'b1; push = 1'b1; rem_d = rem_q - 1'b1;
        end else begin
          state_d = SResp;
        end
      end
      SQuery: begin
        empty_d = 1'b0;
        rsrc_d = held_q.tag; rbeg_d = held_q.key;
        if (rem_q != '0) begin
          rend_d = head33;
          if (all_q) begin
            emit = held_v_q; last_d = rem_q == CntW'(1);
          end else begin
            emit = held_v_q && (head.key > kb_q); last_d = !(head33 < ke_q);
          end
          if (!emit || can_emit) begin
            pop = 1'b1; push = 1'b1; rem_d = rem_q - 1'b1;
            held_d = head; held_v_d = all_q || (head33 < ke_q);
            any_d = any_q || emit;
          end
        end else begin
          rend_d = ke_q; last_d = 1'b1;
          if (!all_q && held_v_q) begin
            emit = 1'b1;
          end else if (!any_q) begin
            emit = 1'b1; empty_d = 1'b1; rsrc_d = '0; rbeg_d = '0; rend_d = '0;
          end
          if (!emit || can_emit) begin
            state_d = SIdle;
          end
        end
      end
      SResp: begin
        emit = 1'b1; status_d = resp_q;
        if (can_emit) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase

    cnt_d = cnt_q + CntW'(push) - CntW'(pop);
    wpos  = pop ? (cnt_q[IdxW-1:0] - 1'b1) : cnt_q[IdxW-1:0];

    if (cfg_we_i) begin
      cnt_d = CntW'(1); root_d = cfg_root_source_i;
    end
  end

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    entry_t nb;
    always_comb begin
      ctl[i].shift = pop && !cfg_we_i;
      ctl[i].load  = push && !cfg_we_i && (wpos == IdxW'(i));
      ctl[i].data  = push_data;
      if (cfg_we_i && i == 0) begin
        ctl[i].load = 1'b1;
        ctl[i].data = '{key: '0, tag: cfg_root_source_i};
      end
    end
    if (i == Entries - 1) begin : g_end
      assign nb = '0;
    end else begin : g_mid
      assign nb = cells[i+1];
    end
    imaq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl[i]),
      .nb_i    (nb),
      .entry_o (cells[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; cnt_q <= CntW'(1); rem_q <= '0; rm_q <= '0;
      root_q <= '0; all_q <= 1'b0; insb_q <= 1'b0; inse_q <= 1'b0;
      held_v_q <= 1'b0; any_q <= 1'b0; resp_q <= StOk; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; rem_q <= rem_d; rm_q <= rm_d;
      root_q <= root_d; all_q <= all_d; insb_q <= insb_d; inse_q <= inse_d;
      held_v_q <= held_v_d; any_q <= any_d; resp_q <= resp_d;
      if (emit && can_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // root tag is held with the beat; a following assign may repaint key zero
  always_ff @(posedge clk_i) begin
    kb_q <= kb_d; ke_q <= ke_d; src_q <= src_d; tib_q <= tib_d; tie_q <= tie_d;
    held_q <= held_d;
    if (emit && can_emit) begin
      status_q <= status_d; rsrc_q <= rsrc_d; rbeg_q <= rbeg_d; rend_q <= rend_d;
      empty_q <= empty_d; last_q <= last_d; rroot_q <= root_q;
    end
  end

  assign in_ready_o        = state_q == SIdle;
  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign range_source_o    = rsrc_q;
  assign range_begin_o     = rbeg_q;
  assign range_end_o       = rend_q;
  assign empty_res_o       = empty_q;
  assign last_o            = last_q;
  assign root_source_res_o = rroot_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != '0 && cnt_q <= CntW'(Entries))
    else $error("entry count out of range");

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && !pop && !cfg_we_i && cnt_q == CntW'(Entries)))
    else $error("push into a full chain");

  a_cfg_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> cnt_q == CntW'(1))
    else $error("table not reinitialised after root write");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_res_o |-> last_o)
    else $error("empty result that is not the last beat");

endmodule
